// File: rtl/sialu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sialu_pkg
// Shared types, constants and the microcode program of the signed ALU.
// ----------------------------------------------------------------------------
package sialu_pkg;

  // operand and result width
  localparam int DATA_WIDTH = 32;
  localparam int OP_W       = 3;
  localparam int UPC_W      = 4;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // operation codes on the input channel
  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_t;

  // input and result beats
  typedef struct packed {
    logic [OP_W-1:0]              operation;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result;
    logic                         divide_by_zero;
  } out_beat_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    UOP_ADD      = 4'd0,
    UOP_SUB      = 4'd1,
    UOP_CLR      = 4'd2,
    UOP_MUL_INIT = 4'd3,
    UOP_MUL_STEP = 4'd4,
    UOP_DIV_INIT = 4'd5,
    UOP_DIV_STEP = 4'd6,
    UOP_DIV_FIX  = 4'd7,
    UOP_DZ       = 4'd8
  } uop_t;

  // jump conditions
  typedef enum logic [1:0] {
    JC_NONE   = 2'd0,
    JC_ALWAYS = 2'd1,
    JC_CNT_NZ = 2'd2,
    JC_DIVZ   = 2'd3
  } jc_t;

  // one control word
  typedef struct packed {
    uop_t             uop;
    jc_t              jc;
    logic [UPC_W-1:0] target;
    logic             fin;
    logic             ld_cnt;
  } ucw_t;

  // program addresses
  localparam logic [UPC_W-1:0] UPC_ADD      = 4'd0;
  localparam logic [UPC_W-1:0] UPC_SUB      = 4'd1;
  localparam logic [UPC_W-1:0] UPC_CLR      = 4'd2;
  localparam logic [UPC_W-1:0] UPC_MUL_INIT = 4'd3;
  localparam logic [UPC_W-1:0] UPC_MUL_STEP = 4'd4;
  localparam logic [UPC_W-1:0] UPC_DIV_INIT = 4'd5;
  localparam logic [UPC_W-1:0] UPC_DIV_STEP = 4'd6;
  localparam logic [UPC_W-1:0] UPC_DIV_FIX  = 4'd7;
  localparam logic [UPC_W-1:0] UPC_DZ       = 4'd8;
  localparam logic [UPC_W-1:0] UPC_LAST     = UPC_DZ;

  // control from sequencer to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic fin;
    uop_t uop;
  } ctrl_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic b_zero;
  } stat_t;

  // program entry per operation
  function automatic logic [UPC_W-1:0] entry_addr(input logic [OP_W-1:0] op);
    logic [UPC_W-1:0] a;
    unique case (op) inside
      OP_ADD:         a = UPC_ADD;
      OP_SUB:         a = UPC_SUB;
      OP_MUL:         a = UPC_MUL_INIT;
      OP_DIV, OP_REM: a = UPC_DIV_INIT;
      default:        a = UPC_CLR;
    endcase
    return a;
  endfunction

  // microcode rom
  function automatic ucw_t ucode(input logic [UPC_W-1:0] upc);
    ucw_t w;
    unique case (upc)
      UPC_ADD:      w = '{UOP_ADD,      JC_NONE,   UPC_ADD,      1'b1, 1'b0};
      UPC_SUB:      w = '{UOP_SUB,      JC_NONE,   UPC_ADD,      1'b1, 1'b0};
      UPC_CLR:      w = '{UOP_CLR,      JC_NONE,   UPC_ADD,      1'b1, 1'b0};
      UPC_MUL_INIT: w = '{UOP_MUL_INIT, JC_NONE,   UPC_ADD,      1'b0, 1'b1};
      UPC_MUL_STEP: w = '{UOP_MUL_STEP, JC_CNT_NZ, UPC_MUL_STEP, 1'b1, 1'b0};
      UPC_DIV_INIT: w = '{UOP_DIV_INIT, JC_DIVZ,   UPC_DZ,       1'b0, 1'b1};
      UPC_DIV_STEP: w = '{UOP_DIV_STEP, JC_CNT_NZ, UPC_DIV_STEP, 1'b0, 1'b0};
      UPC_DIV_FIX:  w = '{UOP_DIV_FIX,  JC_NONE,   UPC_ADD,      1'b1, 1'b0};
      UPC_DZ:       w = '{UOP_DZ,       JC_NONE,   UPC_ADD,      1'b1, 1'b0};
      default:      w = '{UOP_CLR,      JC_NONE,   UPC_ADD,      1'b1, 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/signed_int_alu_mul_div_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_alu_mul_div_mod
// Signed add, subtract, multiply, divide and remainder over 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one beat of operation, operand_a, operand_b.
//   out_valid/out_ready carry one beat of result and divide_by_zero.
//   A short microcode program runs each beat on one shared datapath.
//   Microcode program per operation:
//     add, subtract, unused codes : the add, subtract or clear step
//     multiply                    : init, then a shift-add loop (one bit per step)
//     divide, remainder           : init, a restoring loop (one quotient bit per step), sign fix
//     zero divisor                : init, then the divide-by-zero step
//   One beat is in flight at a time; in_ready rises as the
//   result is written to the output register, so the output register may
//   still hold a beat while the next input is taken and worked on.
//   When out_ready is low while the output register is full and a new
//   result is due, the sequencer holds on its last step until it drains.
//   Reset (rst_n low, synchronous) drops out_valid and returns the
//   sequencer to idle; no memory needs clearing.
// ----------------------------------------------------------------------------
module signed_int_alu_mul_div_mod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sialu_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sialu_pkg::out_beat_t  out_data
);

  sialu_pkg::ctrl_t      ctrl;
  sialu_pkg::stat_t      stat;
  sialu_pkg::out_beat_t  res;
  logic                  out_valid_r, out_valid_nxt;
  sialu_pkg::out_beat_t  out_data_r;
  logic                  out_hold;

  assign out_hold = out_valid_r && !out_ready;

  // sequencer
  sialu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_ready (in_ready),
    .out_hold (out_hold),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath
  sialu_dp u_dp (
    .clk     (clk),
    .in_data (in_data),
    .ctrl    (ctrl),
    .stat    (stat),
    .res     (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.exec && ctrl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && ctrl.fin) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.exec && ctrl.fin) |-> !out_hold)
    else $error("result register overwritten");

  // an accepted beat sets the block busy and drops in_ready
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a beat");

  // the zero divisor flag only comes with a zero divisor, on the zero or dividend result path
  a_dz_only_divrem: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.exec && ctrl.fin && res.divide_by_zero) |-> stat.b_zero)
    else $error("divide by zero flagged with nonzero divisor");

endmodule

// File: rtl/sialu_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sialu_seq
// Microcode sequencer: program counter, loop counter and jump logic.
// ----------------------------------------------------------------------------
module sialu_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [sialu_pkg::OP_W-1:0]          in_op,
  output logic                                in_ready,
  input  logic                                out_hold,
  input  sialu_pkg::stat_t                    stat,
  output sialu_pkg::ctrl_t                    ctrl
);

  logic                           busy_r, busy_nxt;
  logic [sialu_pkg::UPC_W-1:0]    upc_r, upc_nxt;
  logic [sialu_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  sialu_pkg::ucw_t                ucw;
  logic                           take;
  logic                           fin_now;
  logic                           exec;
  logic                           load;

  // fetch and jump decision
  always_comb begin
    ucw = sialu_pkg::ucode(upc_r);
    unique case (ucw.jc)
      sialu_pkg::JC_ALWAYS: take = 1'b1;
      sialu_pkg::JC_CNT_NZ: take = (cnt_r != '0);
      sialu_pkg::JC_DIVZ:   take = stat.b_zero;
      default:              take = 1'b0;
    endcase
    fin_now = busy_r && ucw.fin && !take;
    // a finishing step waits while the result register is full and out_ready is low
    exec    = busy_r && !(fin_now && out_hold);
    load    = in_valid && !busy_r;
  end

  assign in_ready = !busy_r;
  assign ctrl     = '{load: load, exec: exec, fin: fin_now, uop: ucw.uop};

  // next program counter, loop counter and busy flag
  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      upc_nxt  = sialu_pkg::entry_addr(in_op);
    end else if (exec) begin
      if (take) begin
        upc_nxt = ucw.target;
      end else if (ucw.fin) begin
        busy_nxt = 1'b0;
      end else begin
        upc_nxt = upc_r + 1'b1;
      end
      if (ucw.ld_cnt) begin
        cnt_nxt = sialu_pkg::CNT_W'(sialu_pkg::DATA_WIDTH - 1);
      end else if (ucw.jc == sialu_pkg::JC_CNT_NZ && cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= sialu_pkg::UPC_ADD;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // program counter stays inside the program
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> upc_r <= sialu_pkg::UPC_LAST)
    else $error("upc outside program");

  // the sequencer goes idle only after a finishing step ran
  a_idle_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(fin_now && exec))
    else $error("sequencer left busy without finishing");

  // the loop count never exceeds the word width minus one while the sequencer is busy
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= sialu_pkg::CNT_W'(sialu_pkg::DATA_WIDTH - 1))
    else $error("loop count out of range");

endmodule

// File: rtl/sialu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sialu_dp
// Datapath: adder, shift-add multiply and restoring divide registers.
// ----------------------------------------------------------------------------
module sialu_dp (
  input  logic                  clk,
  input  sialu_pkg::in_beat_t   in_data,
  input  sialu_pkg::ctrl_t      ctrl,
  output sialu_pkg::stat_t      stat,
  output sialu_pkg::out_beat_t  res
);

  localparam int W = sialu_pkg::DATA_WIDTH;

  logic [W-1:0]                 a_r, b_r, acc_r, rem_r;
  logic [sialu_pkg::OP_W-1:0]   op_r;
  logic                         sa_r, sb_r;

  logic [W-1:0]                 mul_sum;
  logic [W:0]                   div_sh;
  logic [W:0]                   div_diff;
  logic                         div_ok;
  logic [W-1:0]                 mag_a, mag_b;
  logic [W-1:0]                 quo_fix, rem_fix;

  // shared arithmetic
  always_comb begin
    mul_sum  = acc_r + (b_r[0] ? a_r : '0);
    div_sh   = {rem_r, a_r[W-1]};
    div_diff = div_sh - {1'b0, b_r};
    div_ok   = !div_diff[W];
    mag_a    = a_r[W-1] ? (W'(0) - a_r) : a_r;
    mag_b    = b_r[W-1] ? (W'(0) - b_r) : b_r;
    quo_fix  = (sa_r ^ sb_r) ? (W'(0) - a_r) : a_r;
    rem_fix  = sa_r ? (W'(0) - rem_r) : rem_r;
  end

  assign stat.b_zero = (b_r == '0);

  // result of the finishing step
  always_comb begin
    res.divide_by_zero = 1'b0;
    case (ctrl.uop)
      sialu_pkg::UOP_ADD:      res.result = a_r + b_r;
      sialu_pkg::UOP_SUB:      res.result = a_r - b_r;
      sialu_pkg::UOP_MUL_STEP: res.result = mul_sum;
      sialu_pkg::UOP_DIV_FIX:  res.result = (op_r == sialu_pkg::OP_DIV) ? quo_fix : rem_fix;
      sialu_pkg::UOP_DZ: begin
        res.result         = (op_r == sialu_pkg::OP_DIV) ? '0 : a_r;
        res.divide_by_zero = 1'b1;
      end
      default:                 res.result = '0;
    endcase
  end

  // operand and working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r  <= in_data.operand_a;
      b_r  <= in_data.operand_b;
      op_r <= in_data.operation;
    end else if (ctrl.exec) begin
      case (ctrl.uop)
        sialu_pkg::UOP_MUL_INIT: begin
          acc_r <= '0;
        end
        sialu_pkg::UOP_MUL_STEP: begin
          acc_r <= mul_sum;
          a_r   <= {a_r[W-2:0], 1'b0};
          b_r   <= {1'b0, b_r[W-1:1]};
        end
        sialu_pkg::UOP_DIV_INIT: begin
          sa_r  <= a_r[W-1];
          sb_r  <= b_r[W-1];
          rem_r <= '0;
          // a zero divisor keeps the dividend as it came in
          if (!stat.b_zero) begin
            a_r <= mag_a;
            b_r <= mag_b;
          end
        end
        sialu_pkg::UOP_DIV_STEP: begin
          rem_r <= div_ok ? div_diff[W-1:0] : div_sh[W-1:0];
          a_r   <= {a_r[W-2:0], div_ok};
        end
        default: begin
        end
      endcase
    end
  end

endmodule
